// ----- src/channel_pitch_volume_effects_macros.svh -----
// Assertion helpers shared by the RTL. Each macro samples on the rising edge of clk
// and is disabled while arst_n is low.
`ifndef CHANNEL_PITCH_VOLUME_EFFECTS_MACROS_SVH
`define CHANNEL_PITCH_VOLUME_EFFECTS_MACROS_SVH

// The condition holds at every edge.
`define CPVE_ASSERT_ALWAYS(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// When the antecedent holds, the consequent holds in the same cycle.
`define CPVE_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// When the antecedent holds, the consequent holds in the next cycle.
`define CPVE_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- src/cpve_pkg.sv -----
package cpve_pkg;

	typedef logic [11:0] pitch_t;
	typedef logic [6:0]  volume_t;

	localparam int SineEntries = 64;
	localparam int PhaseW      = $clog2(SineEntries);

	// Item modes.
	localparam logic [1:0] ModeTick  = 2'd0;
	localparam logic [1:0] ModeSetFx = 2'd1;
	localparam logic [1:0] ModeLoad  = 2'd2;

	// Effect codes.
	localparam logic [3:0] FxNone       = 4'd0;
	localparam logic [3:0] FxSlideUp    = 4'd1;
	localparam logic [3:0] FxSlideDown  = 4'd2;
	localparam logic [3:0] FxPorta      = 4'd3;
	localparam logic [3:0] FxVibrato    = 4'd4;
	localparam logic [3:0] FxVolSlide   = 4'd5;
	localparam logic [3:0] FxPortaVol   = 4'd6;
	localparam logic [3:0] FxVibVol     = 4'd7;
	localparam logic [3:0] FxFineUp     = 4'd8;
	localparam logic [3:0] FxFineDown   = 4'd9;
	localparam logic [3:0] FxSetVol     = 4'd10;
	localparam logic [3:0] FxFineVol    = 4'd11;
	localparam logic [3:0] FxCut        = 4'd12;

	// Configuration register indexes.
	localparam logic CfgMinPitch = 1'b0;
	localparam logic CfgMaxPitch = 1'b1;

	localparam pitch_t  MinPitchRst = 12'd113;
	localparam pitch_t  MaxPitchRst = 12'd856;
	localparam volume_t VolMax      = 7'd64;
	localparam pitch_t  PitchMax    = 12'd4095;

	// One period of the vibrato waveform, amplitude 512.
	localparam logic signed [10:0] SineTab [SineEntries] = '{
		11'sd0,    11'sd50,   11'sd100,  11'sd149,  11'sd196,  11'sd241,  11'sd284,
		11'sd325,  11'sd362,  11'sd396,  11'sd426,  11'sd452,  11'sd473,  11'sd490,
		11'sd502,  11'sd510,  11'sd512,  11'sd510,  11'sd502,  11'sd490,  11'sd473,
		11'sd452,  11'sd426,  11'sd396,  11'sd362,  11'sd325,  11'sd284,  11'sd241,
		11'sd196,  11'sd149,  11'sd100,  11'sd50,   11'sd0,    -11'sd49,  -11'sd99,
		-11'sd148, -11'sd195, -11'sd240, -11'sd283, -11'sd324, -11'sd361, -11'sd395,
		-11'sd425, -11'sd451, -11'sd472, -11'sd489, -11'sd501, -11'sd509, -11'sd511,
		-11'sd509, -11'sd501, -11'sd489, -11'sd472, -11'sd451, -11'sd425, -11'sd395,
		-11'sd361, -11'sd324, -11'sd283, -11'sd240, -11'sd195, -11'sd148, -11'sd99,
		-11'sd49
	};

endpackage

// ----- src/channel_pitch_volume_effects.sv -----
// Effect engine for one playback channel: holds the pitch period, the volume and the
// armed effect, and returns one result beat per input beat.
// Input channel: item_valid/item_stall with mode, effect_code, param_byte, pitch_value,
// volume_value and volume_down. A beat moves when item_valid is high and item_stall low.
// Result channel: result_valid/result_stall with out_pitch and out_volume.
// Configuration: cfg_valid/cfg_ready with cfg_index (0 lower pitch bound, 1 upper pitch
// bound) and cfg_data; cfg_ready is always high. Write only while the block is idle.
// An input beat is registered in the input stage, then the effect logic and channel
// state update write the result register.
// Throughput is one item per cycle while the receiver does not stall; the state update
// is a single add, clamp and one small table-times-depth multiply.
// When the receiver stalls, the result register holds and the input stage still takes
// one more beat; item_stall rises only once that staged beat cannot move forward.
// Reset clears all channel state, sets the pitch bounds to 113 and 856, and empties
// both stages. The block accepts items as soon as reset is released.
`include "channel_pitch_volume_effects_macros.svh"

module channel_pitch_volume_effects (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             item_valid,
	output logic             item_stall,
	input  logic [1:0]       mode,
	input  logic [3:0]       effect_code,
	input  logic [7:0]       param_byte,
	input  cpve_pkg::pitch_t pitch_value,
	input  logic [6:0]       volume_value,
	input  logic             volume_down,
	output logic             result_valid,
	input  logic             result_stall,
	output cpve_pkg::pitch_t  out_pitch,
	output cpve_pkg::volume_t out_volume,
	input  logic             cfg_valid,
	output logic             cfg_ready,
	input  logic             cfg_index,
	input  cpve_pkg::pitch_t cfg_data
);
	import cpve_pkg::*;

	// Limit to max first, then raise to min.
	function automatic pitch_t clamp_pitch(input logic signed [13:0] p, input pitch_t lo,
			input pitch_t hi);
		logic signed [13:0] r;
		r = p;
		if (r > $signed({2'b00, hi})) r = $signed({2'b00, hi});
		if (r < $signed({2'b00, lo})) r = $signed({2'b00, lo});
		return r[11:0];
	endfunction

	function automatic volume_t clamp_vol(input logic signed [9:0] v);
		volume_t r;
		if (v < 10'sd0) r = '0;
		else if (v > $signed({3'b000, VolMax})) r = VolMax;
		else r = v[6:0];
		return r;
	endfunction

	function automatic logic signed [4:0] volslide_rate(input logic [7:0] para);
		logic signed [4:0] r;
		if (para[3:0] != 4'd0) r = -$signed({1'b0, para[3:0]});
		else r = $signed({1'b0, para[7:4]});
		return r;
	endfunction

	// Configuration registers.
	pitch_t pitch_floor_q, pitch_ceil_q;

	// Channel state.
	pitch_t              base_q, goal_q;
	volume_t             vol_q;
	logic signed [8:0]   slide_step_q;
	logic [7:0]          porta_rate_q;
	logic [PhaseW-1:0]   vib_phase_q;
	logic [3:0]          vib_rate_q, vib_depth_q;
	logic signed [4:0]   vol_rate_q;
	logic [7:0]          cut_count_q;
	logic [3:0]          fx_q;

	// Input stage.
	logic                valid_s1;
	logic [1:0]          mode_s1;
	logic [3:0]          code_s1;
	logic [7:0]          para_s1;
	pitch_t              pv_s1;
	logic [6:0]          vv_s1;
	logic                down_s1;

	// Result register.
	logic                result_valid_q;
	pitch_t              out_pitch_q;
	volume_t             out_volume_q;

	// Next-state values.
	pitch_t              n_base, n_goal;
	volume_t             n_vol;
	logic signed [8:0]   n_slide_step;
	logic [7:0]          n_porta_rate;
	logic [PhaseW-1:0]   n_vib_phase;
	logic [3:0]          n_vib_rate, n_vib_depth;
	logic signed [4:0]   n_vol_rate;
	logic [7:0]          n_cut_count;
	logic [3:0]          n_fx;
	pitch_t              shown;

	logic                advance, take, process;

	// Shared arithmetic for the tick effects.
	logic [PhaseW-1:0]   vib_phase_next;
	logic signed [15:0]  vib_prod, vib_adj;
	logic signed [7:0]   vib_off;
	logic signed [13:0]  vib_sum;
	logic [12:0]         porta_up;
	logic signed [12:0]  porta_down;
	logic signed [9:0]   volslide_sum;
	pitch_t              porta_pitch;

	// Handshake: the result register moves when empty or taken; the input stage follows.
	assign advance    = !result_valid_q || !result_stall;
	assign item_stall = valid_s1 && !advance;
	assign take       = item_valid && !item_stall;
	assign process    = valid_s1 && advance;
	assign cfg_ready  = 1'b1;

	assign result_valid = result_valid_q;
	assign out_pitch    = out_pitch_q;
	assign out_volume   = out_volume_q;

	// Vibrato offset: table value times depth over 256, rounded toward zero.
	assign vib_phase_next = vib_phase_q + PhaseW'(vib_rate_q);
	assign vib_prod       = SineTab[vib_phase_next] * $signed({1'b0, vib_depth_q});
	assign vib_adj        = vib_prod + (vib_prod[15] ? 16'sd255 : 16'sd0);
	assign vib_off        = vib_adj[15:8];
	assign vib_sum        = $signed({2'b00, base_q}) + 14'(vib_off);

	// Portamento moves toward the goal and stops on it.
	assign porta_up   = {1'b0, base_q} + {5'b00000, porta_rate_q};
	assign porta_down = $signed({1'b0, base_q}) - $signed({5'b00000, porta_rate_q});

	always_comb begin
		porta_pitch = base_q;
		if (base_q < goal_q) begin
			porta_pitch = (porta_up > {1'b0, goal_q}) ? goal_q : porta_up[11:0];
		end else if (base_q > goal_q) begin
			porta_pitch = (porta_down < $signed({1'b0, goal_q})) ? goal_q : porta_down[11:0];
		end
	end

	assign volslide_sum = $signed({3'b000, vol_q}) + 10'(vol_rate_q);

	// Effect logic for the staged item.
	always_comb begin
		n_base       = base_q;
		n_goal       = goal_q;
		n_vol        = vol_q;
		n_slide_step = slide_step_q;
		n_porta_rate = porta_rate_q;
		n_vib_phase  = vib_phase_q;
		n_vib_rate   = vib_rate_q;
		n_vib_depth  = vib_depth_q;
		n_vol_rate   = vol_rate_q;
		n_cut_count  = cut_count_q;
		n_fx         = fx_q;
		unique case (mode_s1)
			ModeLoad: begin
				n_base = pv_s1;
				n_vol  = clamp_vol($signed({3'b000, vv_s1}));
			end
			ModeSetFx: begin
				n_fx = FxNone;
				unique case (code_s1)
					FxSlideUp: begin
						n_fx = code_s1;
						if (para_s1 != 8'd0) n_slide_step = $signed({1'b0, para_s1});
					end
					FxSlideDown: begin
						n_fx = code_s1;
						if (para_s1 != 8'd0) n_slide_step = -$signed({1'b0, para_s1});
					end
					FxPorta: begin
						n_fx = code_s1;
						if (para_s1 != 8'd0) n_porta_rate = para_s1;
						if (pv_s1 != 12'd0) n_goal = pv_s1;
					end
					FxVibrato: begin
						n_fx = code_s1;
						if (para_s1[7:4] != 4'd0) n_vib_rate = para_s1[7:4];
						if (para_s1[3:0] != 4'd0) n_vib_depth = para_s1[3:0];
					end
					FxVolSlide, FxVibVol: begin
						n_fx       = code_s1;
						n_vol_rate = volslide_rate(para_s1);
					end
					FxPortaVol: begin
						n_fx       = code_s1;
						n_vol_rate = volslide_rate(para_s1);
						if (pv_s1 != 12'd0) n_goal = pv_s1;
					end
					FxFineUp: begin
						n_base = clamp_pitch($signed({2'b00, base_q}) + $signed({6'd0, para_s1}),
							pitch_floor_q, pitch_ceil_q);
					end
					FxFineDown: begin
						n_base = clamp_pitch($signed({2'b00, base_q}) - $signed({6'd0, para_s1}),
							pitch_floor_q, pitch_ceil_q);
					end
					FxSetVol: begin
						n_vol = clamp_vol($signed({2'b00, para_s1}));
					end
					FxFineVol: begin
						if (down_s1)
							n_vol = clamp_vol($signed({3'b000, vol_q}) - $signed({2'b00, para_s1}));
						else
							n_vol = clamp_vol($signed({3'b000, vol_q}) + $signed({2'b00, para_s1}));
					end
					FxCut: begin
						n_fx        = code_s1;
						n_cut_count = para_s1;
					end
					default: begin
					end
				endcase
			end
			ModeTick: begin
				unique case (fx_q)
					FxSlideUp, FxSlideDown: begin
						n_base = clamp_pitch($signed({2'b00, base_q}) + 14'(slide_step_q),
							pitch_floor_q, pitch_ceil_q);
					end
					FxPorta: n_base = porta_pitch;
					FxVibrato: n_vib_phase = vib_phase_next;
					FxVolSlide: n_vol = clamp_vol(volslide_sum);
					FxPortaVol: begin
						n_base = porta_pitch;
						n_vol  = clamp_vol(volslide_sum);
					end
					FxVibVol: begin
						n_vib_phase = vib_phase_next;
						n_vol       = clamp_vol(volslide_sum);
					end
					FxCut: begin
						if (cut_count_q != 8'd0) begin
							n_cut_count = cut_count_q - 8'd1;
							if (cut_count_q == 8'd1) n_vol = '0;
						end
					end
					default: begin
					end
				endcase
			end
			default: begin
			end
		endcase
	end

	// Shown pitch: base plus vibrato offset on a vibrato tick, saturated to 12 bits.
	always_comb begin
		shown = n_base;
		if (mode_s1 == ModeTick && (fx_q == FxVibrato || fx_q == FxVibVol)) begin
			if (vib_sum < 14'sd0) shown = '0;
			else if (vib_sum > $signed({2'b00, PitchMax})) shown = PitchMax;
			else shown = vib_sum[11:0];
		end
	end

	// Configuration writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pitch_floor_q <= MinPitchRst;
			pitch_ceil_q  <= MaxPitchRst;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CfgMinPitch: pitch_floor_q <= cfg_data;
				CfgMaxPitch: pitch_ceil_q  <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// Input stage valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	// Input stage payload.
	always_ff @(posedge clk) begin
		if (take) begin
			mode_s1 <= mode;
			code_s1 <= effect_code;
			para_s1 <= param_byte;
			pv_s1   <= pitch_value;
			vv_s1   <= volume_value;
			down_s1 <= volume_down;
		end
	end

	// Channel state update.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q       <= '0;
			goal_q       <= '0;
			vol_q        <= '0;
			slide_step_q <= '0;
			porta_rate_q <= '0;
			vib_phase_q  <= '0;
			vib_rate_q   <= '0;
			vib_depth_q  <= '0;
			vol_rate_q   <= '0;
			cut_count_q  <= '0;
			fx_q         <= FxNone;
		end else if (process) begin
			base_q       <= n_base;
			goal_q       <= n_goal;
			vol_q        <= n_vol;
			slide_step_q <= n_slide_step;
			porta_rate_q <= n_porta_rate;
			vib_phase_q  <= n_vib_phase;
			vib_rate_q   <= n_vib_rate;
			vib_depth_q  <= n_vib_depth;
			vol_rate_q   <= n_vol_rate;
			cut_count_q  <= n_cut_count;
			fx_q         <= n_fx;
		end
	end

	// Result register valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (process) begin
			result_valid_q <= 1'b1;
		end else if (!result_stall) begin
			result_valid_q <= 1'b0;
		end
	end

	// Result register payload.
	always_ff @(posedge clk) begin
		if (process) begin
			out_pitch_q  <= shown;
			out_volume_q <= n_vol;
		end
	end

	`CPVE_ASSERT_ALWAYS(a_vol_range, vol_q <= VolMax, "channel volume above 64")
	`CPVE_ASSERT_SAME(a_stall_needs_stage, item_stall, valid_s1,
		"input stalled with an empty input stage")
	`CPVE_ASSERT_NEXT(a_load_sets_pitch, process && mode_s1 == ModeLoad,
		base_q == $past(pv_s1), "load note did not set the base pitch")
	`CPVE_ASSERT_NEXT(a_cut_silences,
		process && mode_s1 == ModeTick && fx_q == FxCut && cut_count_q == 8'd1,
		vol_q == '0 && result_valid, "note cut did not silence the channel")

endmodule
